[hdl/hne_pkg.sv]
package hne_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int IDX_W = $clog2(MAX_WIDTH);
   localparam int CW = 11;
   localparam int RW = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_STEPS = 49;
   localparam int SQRT_STEPS = 25;
   localparam int STEP_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] height_sample;
   } req_type;

   typedef struct packed {
      logic [7:0] normal_x_code;
      logic [7:0] normal_y_code;
      logic [7:0] normal_z_code;
      logic [7:0] alpha_height;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic             load;
      logic             push;
      logic [IDX_W-1:0] x;
      logic [IDX_W-1:0] xr;
      logic [IDX_W-1:0] xl;
      logic             sel;
      logic [7:0]       sample;
      logic             dy_en;
      logic             last;
      logic             rd_first;
      logic             wr;
      logic             fetch;
      logic             norm;
      logic             div_step;
      logic             div_first;
      logic             sqrt_step;
      logic             sqrt_first;
      logic             enc;
      logic             pack;
   } cmd_type;

endpackage

[hdl/heightmap_normal_encoder.sv]
// An item that yields a normal goes from its transfer through the read, fetch and norm
// states, with two row-buffer reads, then bit-serial division, bit-serial square root,
// encoding and packing; the next transfer waits until it is packed, which a held result
// can delay. A first-row push only writes its row buffer; an ignored item is dropped.
// The result register frees the input side while a result waits to be taken.
// Reset clears the counters and sets the size to 1024 by 1024; row buffers keep stale data.
module heightmap_normal_encoder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  hne_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output hne_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [hne_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hne_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hne_pkg::*;

   cmd_type ctrl_cmd;

   hne_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (ctrl_cmd)
   );

   hne_datapath u_datapath (
      .clock    (clock),
      .cmd      (ctrl_cmd),
      .rsp_data (rsp_data)
   );

   a_rise_after_pack: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(ctrl_cmd.pack))
      else $error("result valid rose without a pack");

   a_load_on_transfer: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.load |-> (req_valid && !req_stall))
      else $error("datapath loaded without an input transfer");

   a_pack_has_room: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.pack |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(ctrl_cmd.div_step && ctrl_cmd.sqrt_step))
      else $error("divider and square root stepped together");

endmodule

[hdl/hne_ctrl.sv]
module hne_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  hne_pkg::req_type                    req_data,
   output logic                                req_stall,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                csr_wr_en,
   input  logic [hne_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hne_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output hne_pkg::cmd_type                    cmd
);
   import hne_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_READ  = 8'b00000010,
      ST_FETCH = 8'b00000100,
      ST_NORM  = 8'b00001000,
      ST_DIV   = 8'b00010000,
      ST_SQRT  = 8'b00100000,
      ST_ENC   = 8'b01000000,
      ST_PACK  = 8'b10000000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              emit_ff, emit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]     width_ff, width_in;
   logic [RW-1:0]     height_ff, height_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [CW-1:0]     drn_ff, drn_in;
   logic [RW-1:0]     row_ff, row_in;
   logic              pend_ff, pend_in;
   logic              sel_ff, sel_in;

   logic [CW-1:0] eff_w, w_m1, col_c, drn_d, pos, pos_nx, pos_r, pos_l;
   logic [RW-1:0] eff_h, row_nx;
   logic          is_drain, accept, do_work, pos_end;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = CW'(1);
      end else if (width_ff > CW'(MAX_WIDTH)) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      w_m1 = eff_w - CW'(1);
      eff_h = (height_ff == '0) ? RW'(1) : height_ff;
      col_c = (col_ff >= eff_w) ? w_m1 : col_ff;
      drn_d = (drn_ff >= eff_w) ? w_m1 : drn_ff;
      is_drain = req_data.func;
      pos = is_drain ? drn_d : col_c;
      pos_nx = pos + CW'(1);
      pos_end = (pos_nx >= eff_w);
      pos_r = pos_end ? '0 : pos_nx;
      pos_l = (pos == '0) ? w_m1 : pos - CW'(1);
      row_nx = row_ff + RW'(1);
      accept = req_valid && (state_ff == ST_IDLE);
      // Pushes count only outside the drain phase, drains only inside it.
      do_work = accept && (is_drain == pend_ff);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.load = do_work;
      cmd.push = !is_drain;
      cmd.x = pos[IDX_W-1:0];
      cmd.xr = pos_r[IDX_W-1:0];
      cmd.xl = pos_l[IDX_W-1:0];
      cmd.sel = sel_ff;
      cmd.sample = req_data.height_sample;
      cmd.dy_en = !is_drain && (row_ff > RW'(1)) && (row_ff < eff_h);
      cmd.last = is_drain && pos_end;
      cmd.rd_first = (state_ff == ST_READ);
      cmd.wr = (state_ff == ST_READ);
      cmd.fetch = (state_ff == ST_FETCH);
      cmd.norm = (state_ff == ST_NORM);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.div_first = (state_ff == ST_DIV) && (step_ff == STEP_W'(DIV_STEPS - 1));
      cmd.sqrt_step = (state_ff == ST_SQRT);
      cmd.sqrt_first = (state_ff == ST_SQRT) && (step_ff == STEP_W'(SQRT_STEPS - 1));
      cmd.enc = (state_ff == ST_ENC);
      cmd.pack = (state_ff == ST_PACK) && !(rsp_valid_ff && rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      emit_in = emit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (do_work) begin
               state_in = ST_READ;
               emit_in = is_drain || (row_ff != '0);
            end
         end
         ST_READ: begin
            state_in = emit_ff ? ST_FETCH : ST_IDLE;
         end
         ST_FETCH: begin
            state_in = ST_NORM;
         end
         ST_NORM: begin
            state_in = ST_DIV;
            step_in = STEP_W'(DIV_STEPS - 1);
         end
         ST_DIV: begin
            if (step_ff == '0) begin
               state_in = ST_SQRT;
               step_in = STEP_W'(SQRT_STEPS - 1);
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_SQRT: begin
            if (step_ff == '0) begin
               state_in = ST_ENC;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_ENC: begin
            state_in = ST_PACK;
         end
         ST_PACK: begin
            if (cmd.pack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.pack) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      col_in = col_ff;
      drn_in = drn_ff;
      row_in = row_ff;
      pend_in = pend_ff;
      sel_in = sel_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in = csr_wdata[CW-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[RW-1:0];
            default: ;
         endcase
      end
      if (do_work) begin
         if (is_drain) begin
            if (pos_end) begin
               pend_in = 1'b0;
               drn_in = '0;
               row_in = '0;
               col_in = '0;
            end else begin
               drn_in = pos_nx;
            end
         end else if (pos_end) begin
            // End of row: the row just written becomes the recent one.
            col_in = '0;
            sel_in = !sel_ff;
            if ((row_nx >= eff_h) || (row_nx == '0)) begin
               row_in = '0;
               pend_in = 1'b1;
               drn_in = '0;
            end else begin
               row_in = row_nx;
            end
         end else begin
            col_in = pos_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         emit_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff <= CW'(1024);
         height_ff <= RW'(1024);
         col_ff <= '0;
         drn_ff <= '0;
         row_ff <= '0;
         pend_ff <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         emit_ff <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff <= width_in;
         height_ff <= height_in;
         col_ff <= col_in;
         drn_ff <= drn_in;
         row_ff <= row_in;
         pend_ff <= pend_in;
         sel_ff <= sel_in;
      end
   end

endmodule

[hdl/hne_datapath.sv]
module hne_datapath (
   input  logic             clock,
   input  hne_pkg::cmd_type cmd,
   output hne_pkg::rsp_type rsp_data
);
   import hne_pkg::*;

   logic [7:0] bank0_mem [MAX_WIDTH];
   logic [7:0] bank1_mem [MAX_WIDTH];

   logic [IDX_W-1:0] x_ff, xr_ff, xl_ff;
   logic             sel_ff, push_ff, dy_en_ff, last_ff;
   logic [7:0]       sample_ff;
   logic [7:0]       b0_a_ff, b0_b_ff, b1_a_ff, b1_b_ff;
   logic [IDX_W-1:0] addr0_a, addr1_a;
   logic [7:0]       rec_a, rec_b, old_a;

   logic signed [8:0]  dx_ff, dy_ff;
   logic [7:0]         alpha_ff;
   logic [16:0]        s_ff;
   logic signed [17:0] dx_sq, dy_sq;
   logic [17:0]        s_sum;

   logic [16:0] rem_ff, rem_cur;
   logic [17:0] rem_sh;
   logic [48:0] quo_ff;
   logic        qbit;

   logic [48:0] v_ff, v_cur, res_ff, res_cur, bit_ff, bit_cur;
   logic [49:0] trial;
   logic        ge;

   logic signed [25:0] inv_s;
   logic signed [9:0]  ax, ay;
   logic signed [35:0] cx_ff, cy_ff, cz_ff;
   logic               last_q_ff;
   rsp_type            rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= cmd.x;
         xr_ff <= cmd.xr;
         xl_ff <= cmd.xl;
         sel_ff <= cmd.sel;
         push_ff <= cmd.push;
         dy_en_ff <= cmd.dy_en;
         last_ff <= cmd.last;
         sample_ff <= cmd.sample;
      end
   end

   // The bank at sel holds the recent row; the other one holds the older row.
   always_comb begin
      addr0_a = (!sel_ff && cmd.rd_first) ? xr_ff : x_ff;
      addr1_a = (sel_ff && cmd.rd_first) ? xr_ff : x_ff;
      rec_a = sel_ff ? b1_a_ff : b0_a_ff;
      rec_b = sel_ff ? b1_b_ff : b0_b_ff;
      old_a = sel_ff ? b0_a_ff : b1_a_ff;
   end

   always_ff @(posedge clock) begin
      b0_a_ff <= bank0_mem[addr0_a];
      b0_b_ff <= bank0_mem[xl_ff];
      if (cmd.wr && push_ff && sel_ff) begin
         bank0_mem[x_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      b1_a_ff <= bank1_mem[addr1_a];
      b1_b_ff <= bank1_mem[xl_ff];
      if (cmd.wr && push_ff && !sel_ff) begin
         bank1_mem[x_ff] <= sample_ff;
      end
   end

   always_comb begin
      dx_sq = dx_ff * dx_ff;
      dy_sq = dy_ff * dy_ff;
      s_sum = 18'(dx_sq) + 18'(dy_sq) + 18'd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         dx_ff <= $signed({1'b0, rec_a}) - $signed({1'b0, rec_b});
         dy_ff <= dy_en_ff ? ($signed({1'b0, sample_ff}) - $signed({1'b0, old_a}))
                           : 9'sd0;
      end
      if (cmd.norm) begin
         alpha_ff <= rec_a;
         s_ff <= s_sum[16:0];
      end
   end

   // Restoring division of 2^48 by s, one quotient bit per cycle.
   always_comb begin
      rem_cur = cmd.div_first ? '0 : rem_ff;
      rem_sh = {rem_cur, cmd.div_first};
      qbit = (rem_sh >= {1'b0, s_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.div_step) begin
         rem_ff <= qbit ? 17'(rem_sh - {1'b0, s_ff}) : rem_sh[16:0];
         quo_ff <= {quo_ff[47:0], qbit};
      end
   end

   // Integer square root, one result bit per cycle.
   always_comb begin
      v_cur = cmd.sqrt_first ? quo_ff : v_ff;
      res_cur = cmd.sqrt_first ? '0 : res_ff;
      bit_cur = cmd.sqrt_first ? (49'd1 << 48) : bit_ff;
      trial = {1'b0, res_cur} + {1'b0, bit_cur};
      ge = ({1'b0, v_cur} >= trial);
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_step) begin
         v_ff <= ge ? 49'({1'b0, v_cur} - trial) : v_cur;
         res_ff <= ge ? ((res_cur >> 1) + bit_cur) : (res_cur >> 1);
         bit_ff <= bit_cur >> 2;
      end
   end

   always_comb begin
      inv_s = $signed({1'b0, res_ff[24:0]});
      ax = -10'(dx_ff);
      ay = -10'(dy_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.enc) begin
         cx_ff <= ax * inv_s + 36'sd16777216;
         cy_ff <= ay * inv_s + 36'sd16777216;
         cz_ff <= 36'(inv_s) + 36'sd16777216;
         last_q_ff <= last_ff;
      end
   end

   function automatic logic [7:0] to_code(input logic signed [35:0] c);
      logic [25:0] cc;
      logic [33:0] m;
      cc = (c < 0) ? '0 : c[25:0];
      m = 34'(cc) * 34'd255;
      return m[32:25];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.pack) begin
         rsp_ff.normal_x_code <= to_code(cx_ff);
         rsp_ff.normal_y_code <= to_code(cy_ff);
         rsp_ff.normal_z_code <= to_code(cz_ff);
         rsp_ff.alpha_height <= alpha_ff;
         rsp_ff.frame_last <= last_q_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[test/heightmap_normal_encoder_tb.sv]
`timescale 1ns / 100ps

module heightmap_normal_encoder_tb;
   import hne_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 120;
   localparam int RANDOM_ITEMS = 120;
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   heightmap_normal_encoder uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Shadow copy of the block's line buffers, counters and size registers.
   logic [7:0] line_recent [0:MAX_WIDTH-1];
   logic [7:0] line_older [0:MAX_WIDTH-1];
   int unsigned col_pos;
   int unsigned row_pos;
   int unsigned drain_pos;
   bit drain_armed;
   logic [10:0] width_reg;
   logic [15:0] height_reg;

   req_type sample_q[$];
   rsp_type normal_q[$];
   int errors;
   int normals_seen;
   int send_gap;
   int stall_left;
   int hold_left;
   bit held;
   int idle_cycles;
   bit quiet;

   // Rows of extreme heights, the first two in a checkerboard, for the first directed frame.
   logic [7:0] w_pattern [0:10] = '{8'd0, 8'd255, 8'd0, 8'd255,
                                    8'd255, 8'd0, 8'd255, 8'd0,
                                    8'd0, 8'd0, 8'd255};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [7:0] code_of(input longint a, input longint unsigned inv);
      longint c;
      longint unsigned p;
      c = a * longint'(inv) + (longint'(1) << 24);
      if (c < 0) c = 0;
      p = (longint'(c) * 255) >> 25;
      return p[7:0];
   endfunction

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic rsp_type normal_at(input int unsigned x, input int unsigned w,
                                         input int dy, input logic last);
      rsp_type r;
      int dx;
      longint unsigned s;
      longint unsigned inv;
      dx = int'(line_recent[(x + 1) % w]) - int'(line_recent[(x + w - 1) % w]);
      s = longint'(dx) * dx + longint'(dy) * dy + 1;
      inv = int_sqrt((64'd1 << 48) / s);
      r.normal_x_code = code_of(-dx, inv);
      r.normal_y_code = code_of(-dy, inv);
      r.normal_z_code = code_of(1, inv);
      r.alpha_height = line_recent[x];
      r.frame_last = last;
      return r;
   endfunction

   task automatic predict_normal(input req_type it);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned d;
      int dy;
      logic [7:0] t;
      w = eff_width();
      h = (height_reg == 0) ? 1 : height_reg;
      if (it.func == FUNC_DRAIN) begin
         if (!drain_armed) return;
         d = (drain_pos >= w) ? w - 1 : drain_pos;
         normal_q.push_back(normal_at(d, w, 0, d + 1 >= w));
         if (d + 1 >= w) begin
            drain_armed = 0;
            drain_pos = 0;
            row_pos = 0;
            col_pos = 0;
         end else begin
            drain_pos = d + 1;
         end
         return;
      end
      if (drain_armed) return;
      c = (col_pos >= w) ? w - 1 : col_pos;
      if (row_pos >= 1) begin
         dy = 0;
         if (row_pos - 1 != 0 && row_pos < h)
            dy = int'(it.height_sample) - int'(line_older[c]);
         normal_q.push_back(normal_at(c, w, dy, 1'b0));
      end
      line_older[c] = it.height_sample;
      c++;
      if (c >= w) begin
         c = 0;
         for (int i = 0; i < MAX_WIDTH; i++) begin
            t = line_recent[i];
            line_recent[i] = line_older[i];
            line_older[i] = t;
         end
         row_pos = (row_pos + 1) & 16'hFFFF;
         if (row_pos >= h || row_pos == 0) begin
            row_pos = 0;
            drain_armed = 1;
            drain_pos = 0;
         end
      end
      col_pos = c;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   // Driver: the payload only moves after a transfer or while valid is low.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) predict_normal(req_data);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
               req_data <= sample_q.pop_front();
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 11) == 0) send_gap <= $urandom_range(1, 7);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each transfer and drives the stall pattern.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         held <= 1'b0;
         normals_seen <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            normals_seen <= normals_seen + 1;
            if (normal_q.size() == 0) begin
               $display("unexpected normal at %0t", $time);
               errors++;
            end else begin
               want = normal_q.pop_front();
               if (rsp_data.normal_x_code !== want.normal_x_code)
                  report_mismatch("normal_x_code", rsp_data.normal_x_code, want.normal_x_code);
               if (rsp_data.normal_y_code !== want.normal_y_code)
                  report_mismatch("normal_y_code", rsp_data.normal_y_code, want.normal_y_code);
               if (rsp_data.normal_z_code !== want.normal_z_code)
                  report_mismatch("normal_z_code", rsp_data.normal_z_code, want.normal_z_code);
               if (rsp_data.alpha_height !== want.alpha_height)
                  report_mismatch("alpha_height", rsp_data.alpha_height, want.alpha_height);
               if (rsp_data.frame_last !== want.frame_last)
                  report_mismatch("frame_last", rsp_data.frame_last, want.frame_last);
            end
         end
         // One long hold while items are still queued, so the block backs up.
         if (!held && sample_q.size() > 4 && rsp_valid && !rsp_stall) begin
            held <= 1'b1;
            hold_left <= 600;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[heightmap_normal_encoder] ERROR");
            $finish;
         end
      end
   end

   task automatic add_item(input logic f, input logic [7:0] s);
      req_type it;
      it.func = f;
      it.height_sample = s;
      sample_q.push_back(it);
   endtask

   function automatic logic [7:0] pick_height();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_pushes(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) add_item(FUNC_DRAIN, 8'($urandom_range(0, 255)));
         add_item(FUNC_PUSH, pick_height());
      end
   endtask

   task automatic add_drains(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) add_item(FUNC_PUSH, 8'($urandom_range(0, 255)));
         add_item(FUNC_DRAIN, 8'($urandom_range(0, 255)));
      end
   endtask

   // Waits until the block has drained everything, then lets it settle.
   task automatic wait_idle();
      do @(posedge clock);
      while (sample_q.size() != 0 || req_valid || normal_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_IMAGE_WIDTH) width_reg = value[10:0];
      else height_reg = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_size(input logic [15:0] w, input logic [15:0] h);
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
   endtask

   initial begin
      int issued;
      int w;
      int h;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0;
      quiet = 0;
      col_pos = 0;
      row_pos = 0;
      drain_pos = 0;
      drain_armed = 0;
      width_reg = 11'd1024;
      height_reg = 16'd1024;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         line_recent[i] = '0;
         line_older[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Small frame with extreme heights and a stray drain.
      set_size(16'd4, 16'd3);
      add_item(FUNC_DRAIN, 8'd0);
      foreach (w_pattern[i]) add_item(FUNC_PUSH, w_pattern[i]);
      add_item(FUNC_PUSH, 8'd255);
      for (int i = 0; i < 4; i++) add_item(FUNC_DRAIN, 8'd255);

      // Zero sizes behave as one by one.
      set_size(16'd0, 16'd0);
      add_item(FUNC_PUSH, 8'd200);
      add_item(FUNC_DRAIN, 8'd0);

      // Oversized width clamps to the full line buffer; the held row is
      // released after the width is lowered.
      set_size(16'd2047, 16'd1);
      for (int i = 0; i < MAX_WIDTH; i++) add_item(FUNC_PUSH, pick_height());
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, 16'd4);
      add_drains(4);

      // Tallest frame, cut short by lowering the height mid-frame.
      set_size(16'd3, 16'hFFFF);
      add_pushes(7);
      set_size(16'd3, 16'd2);
      add_pushes(2);
      add_drains(3);

      // Width shrinks below the current column.
      set_size(16'd8, 16'd3);
      add_pushes(5);
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, 16'd3);
      add_pushes(7);
      add_drains(3);

      // Width shrinks below the drain position.
      set_size(16'd8, 16'd2);
      add_pushes(16);
      add_drains(5);
      wait_idle();
      csr_write(CSR_IMAGE_WIDTH, 16'd3);
      add_drains(1);

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0: w = 0;
            1: w = $urandom_range(13, 40);
            default: w = $urandom_range(1, 12);
         endcase
         h = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(0, 6);
         if (w > 12 && h > 6) h = 6;
         if (issued > RANDOM_ITEMS * 4 / 5) quiet = 1;
         set_size(16'(w), 16'(h));
         if (w == 0) w = 1;
         if (h == 0) h = 1;
         add_pushes(w * h);
         add_drains(w);
         issued += w * h + w;
      end

      wait_idle();
      if (errors == 0) begin
         $display("[heightmap_normal_encoder] OK");
      end else begin
         $display("[heightmap_normal_encoder] ERROR");
      end
      $finish;
   end

endmodule

[files.f]
hdl/hne_pkg.sv
hdl/hne_ctrl.sv
hdl/hne_datapath.sv
hdl/heightmap_normal_encoder.sv
test/heightmap_normal_encoder_tb.sv
